@@ rtl/sps_pkg.sv @@
// sps_pkg: shared types, constants, microcode encoding and phase/duty tables
// for the stepper phase sequencer; no dependencies, imported by all rtl files

package sps_pkg;

   // register file
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 10;
   localparam logic [CsrIndexW-1:0] CsrDriveMode   = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrRotationDir = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrSpeedRpm    = 2'd2;
   localparam logic [CsrIndexW-1:0] CsrStepsPerRev = 2'd3;

   localparam int ModeW  = 2;
   localparam int RpmW   = 10;
   localparam int SprW   = 9;
   localparam logic [ModeW-1:0] ModeWave  = 2'd0;
   localparam logic [ModeW-1:0] ModeFull  = 2'd1;
   localparam logic [ModeW-1:0] ModeHalf  = 2'd2;
   localparam logic [ModeW-1:0] ModeMicro = 2'd3;
   localparam logic [RpmW-1:0]  RpmReset  = 10'd100;
   localparam logic [SprW-1:0]  SprReset  = 9'd200;

   // result fields
   localparam int LinesW = 4;
   localparam int DutyW  = 7;
   localparam int HoldW  = 16;
   localparam logic [DutyW-1:0] DutyMax  = 7'd100;
   localparam logic [DutyW-1:0] DutyZero = 7'd0;
   localparam logic [HoldW-1:0] HoldSat  = 16'hFFFF;

   localparam int PhaseW = 3;

   // hold time division: 60000000 / (steps_per_rev * k * rpm)
   localparam int DenW      = SprW + RpmW;   // steps_per_rev * rpm
   localparam int DivisorW  = DenW + 3;      // times k of at most 8
   localparam int DividendW = 26;
   localparam logic [DividendW-1:0] HoldNumer = 26'd60000000;
   localparam int DivCntW   = $clog2(DividendW);

   // microstep ramp
   localparam int RampLen  = 8;
   localparam int RampCntW = $clog2(RampLen);
   localparam logic [RampCntW-1:0] RampLast = RampCntW'(RampLen - 1);

   // microcode encoding
   localparam int PcW = 3;
   localparam logic [PcW-1:0] StepIdle     = 3'd0;
   localparam logic [PcW-1:0] StepDivInit  = 3'd1;
   localparam logic [PcW-1:0] StepDivStep  = 3'd2;
   localparam logic [PcW-1:0] StepSat      = 3'd3;
   localparam logic [PcW-1:0] StepSingle   = 3'd4;
   localparam logic [PcW-1:0] StepRampUp   = 3'd5;
   localparam logic [PcW-1:0] StepRampDown = 3'd6;

   localparam logic [1:0] WaitNone = 2'd0;
   localparam logic [1:0] WaitReq  = 2'd1;
   localparam logic [1:0] WaitDiv  = 2'd2;
   localparam logic [1:0] WaitRamp = 2'd3;

   localparam logic [1:0] JumpNever  = 2'd0;
   localparam logic [1:0] JumpAlways = 2'd1;
   localparam logic [1:0] JumpMicro  = 2'd2;

   localparam logic [1:0] DutyFull = 2'd0;
   localparam logic [1:0] DutyUp   = 2'd1;
   localparam logic [1:0] DutyDown = 2'd2;
   localparam logic [1:0] DutyKeep = 2'd3;

   typedef struct packed {
      logic           accept;
      logic           div_load;
      logic           div_step;
      logic           sat;
      logic           emit;
      logic [1:0]     duty_op;
      logic           phase_adv;
      logic [1:0]     wait_cond;
      logic [1:0]     jump_cond;
      logic [PcW-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   // coil line patterns, bit0 IN1 .. bit3 IN4
   function automatic logic [LinesW-1:0] wave_lines(input logic [1:0] p);
      logic [LinesW-1:0] r;
      case (p)
         2'd0:    r = 4'h1;
         2'd1:    r = 4'h4;
         2'd2:    r = 4'h2;
         default: r = 4'h8;
      endcase
      return r;
   endfunction

   function automatic logic [LinesW-1:0] full_lines(input logic [1:0] p);
      logic [LinesW-1:0] r;
      case (p)
         2'd0:    r = 4'h5;
         2'd1:    r = 4'h6;
         2'd2:    r = 4'hA;
         default: r = 4'h9;
      endcase
      return r;
   endfunction

   function automatic logic [LinesW-1:0] half_lines(input logic [2:0] p);
      logic [LinesW-1:0] r;
      case (p)
         3'd0:    r = 4'h1;
         3'd1:    r = 4'h5;
         3'd2:    r = 4'h4;
         3'd3:    r = 4'h6;
         3'd4:    r = 4'h2;
         3'd5:    r = 4'hA;
         3'd6:    r = 4'h8;
         default: r = 4'h9;
      endcase
      return r;
   endfunction

   // duty ramps in percent
   function automatic logic [DutyW-1:0] ramp_up(input logic [RampCntW-1:0] i);
      logic [DutyW-1:0] r;
      case (i)
         3'd0:    r = 7'd20;
         3'd1:    r = 7'd38;
         3'd2:    r = 7'd56;
         3'd3:    r = 7'd70;
         3'd4:    r = 7'd83;
         3'd5:    r = 7'd92;
         3'd6:    r = 7'd98;
         default: r = 7'd100;
      endcase
      return r;
   endfunction

   function automatic logic [DutyW-1:0] ramp_down(input logic [RampCntW-1:0] i);
      logic [DutyW-1:0] r;
      case (i)
         3'd0:    r = 7'd98;
         3'd1:    r = 7'd92;
         3'd2:    r = 7'd83;
         3'd3:    r = 7'd70;
         3'd4:    r = 7'd56;
         3'd5:    r = 7'd38;
         3'd6:    r = 7'd20;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/sps_ucode_rom.sv @@
// sps_ucode_rom: control store of the step sequencer, one control word per step
// depends on sps_pkg for the control word type and step/condition codes

module sps_ucode_rom import sps_pkg::*; (
   input  logic [PcW-1:0]  pc,
   output ucode_word_type  uword
);

   // program: wait for a request, divide, saturate, then one or sixteen results
   always_comb begin
      uword = '0;
      unique case (pc)
         StepIdle: begin
            uword.accept    = 1'b1;
            uword.duty_op   = DutyKeep;
            uword.wait_cond = WaitReq;
         end
         StepDivInit: begin
            uword.div_load = 1'b1;
            uword.duty_op  = DutyKeep;
         end
         StepDivStep: begin
            uword.div_step  = 1'b1;
            uword.duty_op   = DutyKeep;
            uword.wait_cond = WaitDiv;
         end
         StepSat: begin
            uword.sat       = 1'b1;
            uword.duty_op   = DutyKeep;
            uword.jump_cond = JumpMicro;
            uword.target    = StepRampUp;
         end
         StepSingle: begin
            uword.emit      = 1'b1;
            uword.duty_op   = DutyFull;
            uword.phase_adv = 1'b1;
            uword.jump_cond = JumpAlways;
            uword.target    = StepIdle;
         end
         StepRampUp: begin
            uword.emit      = 1'b1;
            uword.duty_op   = DutyUp;
            uword.wait_cond = WaitRamp;
         end
         StepRampDown: begin
            uword.emit      = 1'b1;
            uword.duty_op   = DutyDown;
            uword.phase_adv = 1'b1;
            uword.wait_cond = WaitRamp;
            uword.jump_cond = JumpAlways;
            uword.target    = StepIdle;
         end
         default: begin
            uword.duty_op   = DutyKeep;
            uword.jump_cond = JumpAlways;
            uword.target    = StepIdle;
         end
      endcase
   end

endmodule

@@ rtl/sps_divider.sv @@
// sps_divider: restoring divider for the hold time, one quotient bit per cycle while ctl.step is high
// depends on sps_pkg for widths, the fixed dividend and the control struct

module sps_divider import sps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctl_type           ctl,
   input  logic [DivisorW-1:0]   divisor,
   output logic [DividendW-1:0]  quotient,
   output logic                  busy
);

   logic [DivisorW-1:0]  rem_ff, rem_in;
   logic [DivisorW-1:0]  dsr_ff;
   logic [DividendW-1:0] quo_ff, quo_in;
   logic [DivCntW-1:0]   cnt_ff, cnt_in;
   logic [DivisorW:0]    trial;
   logic [DivisorW:0]    diff;
   logic                 fits;

   // one trial subtract; a zero divisor always fits and saturates the quotient
   always_comb begin
      trial  = {rem_ff, quo_ff[DividendW-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_in = {quo_ff[DividendW-2:0], fits};
   end

   // iteration count
   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.load) begin
         cnt_in = DivCntW'(DividendW - 1);
      end else if (ctl.step && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rem_ff <= '0;
         quo_ff <= HoldNumer;
         dsr_ff <= divisor;
      end else if (ctl.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;
   assign busy     = cnt_ff != '0;

endmodule

@@ rtl/stepper_phase_sequencer.sv @@
// stepper_phase_sequencer: top level, step counter, config registers and datapath
// depends on sps_pkg, sps_ucode_rom and sps_divider
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_new_move
//   rsp     | out       | rsp_valid/rsp_stall  | coil_lines, duty_a, duty_b, hold_us, last
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// each request runs the hold-time divider before its first result is emitted,
// which produces one quotient bit per cycle
// microstep emits its 16 results one per cycle while the output register drains
// req_stall is low only in the idle step; a pending result does not block a new request
// synchronous reset returns the step counter to idle and the config registers to defaults
// csr_ready is always high

module stepper_phase_sequencer import sps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_new_move,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LinesW-1:0]     rsp_coil_lines,
   output logic [DutyW-1:0]      rsp_duty_a,
   output logic [DutyW-1:0]      rsp_duty_b,
   output logic [HoldW-1:0]      rsp_hold_us,
   output logic                  rsp_last_of_step,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CsrIndexW-1:0]  csr_index,
   input  logic [CsrDataW-1:0]   csr_data
);

   logic [ModeW-1:0]     mode_ff;
   logic                 dir_ff;
   logic [RpmW-1:0]      rpm_ff;
   logic [SprW-1:0]      spr_ff;
   logic [PcW-1:0]       pc_ff, pc_in;
   logic [PhaseW-1:0]    phase_ff;
   logic [RampCntW-1:0]  ramp_ff;
   logic [DenW-1:0]      den_ff;
   logic [HoldW-1:0]     hold_ff;
   logic [DutyW-1:0]     duty_a_ff, duty_b_ff;
   logic [DutyW-1:0]     duty_a_in, duty_b_in;
   logic                 rsp_valid_ff;
   logic [LinesW-1:0]    rsp_lines_ff;
   logic [DutyW-1:0]     rsp_duty_a_ff, rsp_duty_b_ff;
   logic [HoldW-1:0]     rsp_hold_ff;
   logic                 rsp_last_ff;
   ucode_word_type       uword;
   div_ctl_type          div_ctl;
   logic [DivisorW-1:0]  divisor;
   logic [DividendW-1:0] quotient;
   logic                 div_busy;
   logic                 req_acc;
   logic                 out_free;
   logic                 emit_fire;
   logic                 wait_hold;
   logic                 hold;
   logic                 jump_take;
   logic [1:0]           p4;
   logic [2:0]           p8;
   logic                 b_first;
   logic [LinesW-1:0]    lines_in;
   logic                 last_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeWave;
         dir_ff  <= 1'b0;
         rpm_ff  <= RpmReset;
         spr_ff  <= SprReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrDriveMode:   mode_ff <= csr_data[ModeW-1:0];
            CsrRotationDir: dir_ff  <= csr_data[0];
            CsrSpeedRpm:    rpm_ff  <= csr_data[RpmW-1:0];
            CsrStepsPerRev: spr_ff  <= csr_data[SprW-1:0];
            default: ;
         endcase
      end
   end

   // control store
   sps_ucode_rom u_rom (
      .pc    (pc_ff),
      .uword (uword)
   );

   assign req_stall = !uword.accept;
   assign req_acc   = req_valid && uword.accept;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = uword.emit && out_free;

   // wait and jump conditions
   always_comb begin
      case (uword.wait_cond)
         WaitReq:  wait_hold = !req_acc;
         WaitDiv:  wait_hold = div_busy;
         WaitRamp: wait_hold = ramp_ff != RampLast;
         default:  wait_hold = 1'b0;
      endcase
      case (uword.jump_cond)
         JumpAlways: jump_take = 1'b1;
         JumpMicro:  jump_take = mode_ff == ModeMicro;
         default:    jump_take = 1'b0;
      endcase
      hold = (uword.emit && !out_free) || wait_hold;
      if (hold) begin
         pc_in = pc_ff;
      end else if (jump_take) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= StepIdle;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // phase counter: cleared by a new move, advanced after the final result
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (req_acc && req_new_move) begin
         phase_ff <= '0;
      end else if (uword.phase_adv && !hold) begin
         phase_ff <= phase_ff + 1'b1;
      end
   end

   // steps_per_rev * rpm, scaled by k for the divider
   always_ff @(posedge clock) begin
      if (req_acc) begin
         den_ff <= DenW'(spr_ff) * DenW'(rpm_ff);
      end
   end

   always_comb begin
      case (mode_ff)
         ModeHalf:  divisor = {DivisorW'(den_ff)} << 1;
         ModeMicro: divisor = {DivisorW'(den_ff)} << 3;
         default:   divisor = DivisorW'(den_ff);
      endcase
   end

   assign div_ctl.load = uword.div_load;
   assign div_ctl.step = uword.div_step;

   sps_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .divisor  (divisor),
      .quotient (quotient),
      .busy     (div_busy)
   );

   // saturate the quotient to the hold field
   always_ff @(posedge clock) begin
      if (uword.sat) begin
         hold_ff <= (quotient[DividendW-1:HoldW] != '0) ? HoldSat : quotient[HoldW-1:0];
      end
   end

   // ramp position, wraps after the last entry
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff <= '0;
      end else if (emit_fire && (uword.duty_op == DutyUp || uword.duty_op == DutyDown)) begin
         ramp_ff <= (ramp_ff == RampLast) ? '0 : ramp_ff + 1'b1;
      end
   end

   // phase index, reversed for counter-clockwise
   assign p4      = phase_ff[1:0] ^ {2{dir_ff}};
   assign p8      = phase_ff ^ {PhaseW{dir_ff}};
   assign b_first = !p4[0];

   // next duties and coil lines of the result being built
   always_comb begin
      duty_a_in = duty_a_ff;
      duty_b_in = duty_b_ff;
      lines_in  = full_lines(p4);
      last_in   = 1'b0;
      case (uword.duty_op)
         DutyFull: begin
            duty_a_in = DutyMax;
            duty_b_in = DutyMax;
            last_in   = 1'b1;
            if (mode_ff == ModeHalf) begin
               lines_in = half_lines(p8);
            end else if (mode_ff == ModeWave) begin
               lines_in = wave_lines(p4);
            end
         end
         DutyUp: begin
            if (b_first) begin
               duty_b_in = ramp_up(ramp_ff);
            end else begin
               duty_a_in = ramp_up(ramp_ff);
            end
         end
         DutyDown: begin
            if (b_first) begin
               duty_a_in = ramp_down(ramp_ff);
            end else begin
               duty_b_in = ramp_down(ramp_ff);
            end
            last_in = ramp_ff == RampLast;
         end
         default: ;
      endcase
   end

   // held duties, kept across requests
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_a_ff <= DutyMax;
         duty_b_ff <= DutyZero;
      end else if (emit_fire) begin
         duty_a_ff <= duty_a_in;
         duty_b_ff <= duty_b_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_lines_ff  <= lines_in;
         rsp_duty_a_ff <= duty_a_in;
         rsp_duty_b_ff <= duty_b_in;
         rsp_hold_ff   <= hold_ff;
         rsp_last_ff   <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coil_lines   = rsp_lines_ff;
   assign rsp_duty_a       = rsp_duty_a_ff;
   assign rsp_duty_b       = rsp_duty_b_ff;
   assign rsp_hold_us      = rsp_hold_ff;
   assign rsp_last_of_step = rsp_last_ff;

   // an accepted request always starts the divider next
   a_req_starts_div: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (pc_ff == StepDivInit))
      else $error("accepted request did not start the divider");

   // the final microstep result always leaves one bridge fully off
   a_micro_last_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff && mode_ff == ModeMicro)
      |-> (rsp_duty_a_ff == DutyZero || rsp_duty_b_ff == DutyZero))
      else $error("final microstep result with both bridges driven");

   // the phase advances by one together with the final result of a request
   a_phase_adv_last: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && last_in) |=> (phase_ff == PhaseW'($past(phase_ff) + 1'b1)))
      else $error("phase did not advance with the final result");

endmodule
